### src/qip_pkg.sv
// ----------------------------------------------------------------------------
// qip_pkg
// Shared constants and types of the q-intersection projection block.
// ----------------------------------------------------------------------------
`default_nettype none
package qip_pkg;
  localparam int MAX_BOXES_DEF  = 64;
  localparam int MAX_DIMS_DEF   = 16;
  localparam int COORD_BITS_DEF = 32;

  localparam int BOX_W  = 6;
  localparam int DIM_W  = 4;
  localparam int THR_W  = 7;
  localparam int DCNT_W = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DIMS      = 1'b1;

  // control of the sorting row
  typedef struct packed {
    logic clear;
    logic ins;
    logic shift;
  } ctl_t;
endpackage
`default_nettype wire

### src/qip_if.sv
// ----------------------------------------------------------------------------
// qip_if
// Request channels of the q-intersection projection block.
// ----------------------------------------------------------------------------
`default_nettype none
interface qip_in_if #(parameter int COORD_BITS = qip_pkg::COORD_BITS_DEF);
  logic                            valid;
  logic                            ready;
  logic [qip_pkg::BOX_W-1:0]       box_index;
  logic [qip_pkg::DIM_W-1:0]       dim_index;
  logic signed [COORD_BITS-1:0]    lower_bound;
  logic signed [COORD_BITS-1:0]    upper_bound;
  logic                            component_empty;
  logic                            last_item;
  modport source (output valid, box_index, dim_index, lower_bound, upper_bound,
                  component_empty, last_item, input ready);
  modport sink (input valid, box_index, dim_index, lower_bound, upper_bound,
                component_empty, last_item, output ready);
endinterface

interface qip_out_if #(parameter int COORD_BITS = qip_pkg::COORD_BITS_DEF);
  logic                            valid;
  logic                            ready;
  logic [qip_pkg::DIM_W-1:0]       out_dim;
  logic signed [COORD_BITS-1:0]    result_lower;
  logic signed [COORD_BITS-1:0]    result_upper;
  logic                            result_empty;
  logic                            last_result;
  modport source (output valid, out_dim, result_lower, result_upper, result_empty,
                  last_result, input ready);
  modport sink (input valid, out_dim, result_lower, result_upper, result_empty,
                last_result, output ready);
endinterface
`default_nettype wire

### src/q_intersection_projection.sv
// ----------------------------------------------------------------------------
// q_intersection_projection
// q-fold intersection of loaded boxes, projected on each dimension.
// ----------------------------------------------------------------------------
// Usage: load one interval per request on in_ch (box, dimension, ends, empty
// flag). The request with last_item set is stored too and starts the
// computation; in_ch.ready stays low until every result has been taken on
// out_ch. Per dimension the boxes are read from the interval memory (per
// live box: read, insert lower end, insert upper end) into a row of sorting
// cells, then drained smallest first while a running count finds both ends.
// Results sit in a small buffer and go out one per cycle on out_ch once all
// dimensions are done; a stalled receiver simply holds the current result.
// Either one result per dimension or a single empty result is sent.
// Reset (rst_n low, synchronous) clears box flags, box count and registers
// (threshold 1, dimensions 1); the interval memory is not cleared.
// Configuration goes through the cfg_ APB port, registers at 0x0 and 0x4.
// ----------------------------------------------------------------------------
`default_nettype none
module q_intersection_projection #(
  parameter int MAX_BOXES  = qip_pkg::MAX_BOXES_DEF,
  parameter int MAX_DIMS   = qip_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS = qip_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  qip_in_if.sink                            in_ch,
  qip_out_if.source                         out_ch,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire [qip_pkg::PADDR_W-1:0]        cfg_paddr,
  input  wire [qip_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [qip_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  localparam int NCELL  = 2 * MAX_BOXES;
  localparam int NSLOT  = MAX_BOXES * MAX_DIMS;
  localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int BIDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BCNT_W = $clog2(MAX_BOXES + 1);
  localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCW    = $clog2(MAX_DIMS + 1);
  localparam int PCW    = $clog2(NCELL + 1);
  localparam int CW     = $clog2(NCELL + 128) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_INSL  = 3'd3;
  localparam logic [2:0] S_INSU  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DIMND = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_r;
  logic [qip_pkg::THR_W-1:0]  thr_r;
  logic [qip_pkg::DCNT_W-1:0] dcnt_r;
  logic [MAX_BOXES-1:0]       bflag_r;
  logic [BCNT_W-1:0]          bcnt_r;
  logic [BCNT_W-1:0]          b_r;
  logic [DCW-1:0]             d_r, e_r;
  logic [PCW-1:0]             pn_r, k_r;
  logic signed [CW-1:0]       c_r;
  logic                       flo_r, fhi_r, empty_r;
  logic signed [COORD_BITS-1:0] lo_r, hi_r;

  logic [COORD_BITS-1:0] lo_mem [NSLOT];
  logic [COORD_BITS-1:0] up_mem [NSLOT];
  logic [COORD_BITS-1:0] rd_lo_r, rd_up_r;
  logic signed [COORD_BITS-1:0] buf_lo [MAX_DIMS];
  logic signed [COORD_BITS-1:0] buf_hi [MAX_DIMS];

  logic in_acc, in_rng, out_acc;
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  logic [DCW-1:0] dims;
  logic signed [CW-1:0] q_ext, c_nxt;
  qip_pkg::ctl_t ctl;
  logic signed [COORD_BITS-1:0] ins_val, head_val;
  logic ins_up, head_up;
  logic dim_fail, last_dim_e;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[2])
      qip_pkg::REG_THRESHOLD: cfg_prdata = qip_pkg::PDATA_W'(thr_r);
      qip_pkg::REG_DIMS:      cfg_prdata = qip_pkg::PDATA_W'(dcnt_r);
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= qip_pkg::THR_W'(1);
      dcnt_r <= qip_pkg::DCNT_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == qip_pkg::REG_THRESHOLD) begin
        thr_r <= cfg_pwdata[qip_pkg::THR_W-1:0];
      end else begin
        dcnt_r <= cfg_pwdata[qip_pkg::DCNT_W-1:0];
      end
    end
  end

  // effective threshold and dimension count
  always_comb begin
    q_ext = (thr_r == '0) ? CW'(1) : CW'(thr_r);
    if (dcnt_r == '0) begin
      dims = DCW'(1);
    end else if (32'(dcnt_r) > MAX_DIMS) begin
      dims = DCW'(MAX_DIMS);
    end else begin
      dims = DCW'(dcnt_r);
    end
  end

  // ---- load path ----
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_rng = (32'(in_ch.box_index) < MAX_BOXES) && (32'(in_ch.dim_index) < MAX_DIMS);
  assign wr_slot = SLOT_W'(32'(in_ch.box_index) * MAX_DIMS + 32'(in_ch.dim_index));
  assign rd_slot = SLOT_W'(32'(b_r) * MAX_DIMS + 32'(d_r));

  always_ff @(posedge clk) begin
    if (in_acc && in_rng) begin
      lo_mem[wr_slot] <= in_ch.lower_bound;
      up_mem[wr_slot] <= in_ch.upper_bound;
    end
    rd_lo_r <= lo_mem[rd_slot];
    rd_up_r <= up_mem[rd_slot];
  end

  // ---- sorting row ----
  always_comb begin
    ctl.clear = (state_r == S_START);
    ctl.ins   = (state_r == S_INSL) || (state_r == S_INSU);
    ctl.shift = (state_r == S_SCAN) && (k_r != pn_r);
    ins_val   = (state_r == S_INSU) ? rd_up_r : rd_lo_r;
    ins_up    = (state_r == S_INSU);
  end

  qip_chain #(.NCELL(NCELL), .COORD_BITS(COORD_BITS)) u_chain (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_val(ins_val), .new_up(ins_up),
    .head_val(head_val), .head_up(head_up));

  // running count: lower end +1, upper end -1; the upper bound is the last
  // point whose preceding count equals q (same as the downward sweep)
  assign c_nxt    = head_up ? (c_r - CW'(1)) : (c_r + CW'(1));
  assign dim_fail = (pn_r == '0) || !flo_r || !fhi_r;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign last_dim_e = (e_r + DCW'(1) == dims);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bflag_r <= '0;
      bcnt_r  <= '0;
      b_r     <= '0;
      d_r     <= '0;
      e_r     <= '0;
      pn_r    <= '0;
      k_r     <= '0;
      c_r     <= '0;
      flo_r   <= 1'b0;
      fhi_r   <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_rng) begin
              if (in_ch.component_empty) begin
                bflag_r[BIDX_W'(in_ch.box_index)] <= 1'b1;
              end
              if (32'(in_ch.box_index) + 1 > 32'(bcnt_r)) begin
                bcnt_r <= BCNT_W'(32'(in_ch.box_index) + 1);
              end
            end
            if (in_ch.last_item) begin
              d_r     <= '0;
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          b_r     <= '0;
          pn_r    <= '0;
          k_r     <= '0;
          c_r     <= '0;
          flo_r   <= 1'b0;
          fhi_r   <= 1'b0;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          if (b_r == bcnt_r) begin
            state_r <= S_SCAN;
          end else if (bflag_r[b_r[BIDX_W-1:0]]) begin
            b_r <= b_r + BCNT_W'(1);
          end else begin
            state_r <= S_INSL;
          end
        end
        S_INSL: begin
          state_r <= S_INSU;
        end
        S_INSU: begin
          pn_r    <= pn_r + PCW'(2);
          b_r     <= b_r + BCNT_W'(1);
          state_r <= S_ADDR;
        end
        S_SCAN: begin
          if (k_r == pn_r) begin
            state_r <= S_DIMND;
          end else begin
            k_r <= k_r + PCW'(1);
            c_r <= c_nxt;
            if (!flo_r && c_nxt == q_ext) begin
              flo_r <= 1'b1;
              lo_r  <= head_val;
            end
            if (c_r == q_ext) begin
              fhi_r <= 1'b1;
              hi_r  <= head_val;
            end
          end
        end
        S_DIMND: begin
          e_r <= '0;
          if (dim_fail) begin
            empty_r <= 1'b1;
            state_r <= S_EMIT;
          end else if (d_r + DCW'(1) == dims) begin
            empty_r <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            d_r     <= d_r + DCW'(1);
            state_r <= S_START;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (empty_r || last_dim_e) begin
              bflag_r <= '0;
              bcnt_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              e_r <= e_r + DCW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIMND && !dim_fail) begin
      buf_lo[d_r[DIDX_W-1:0]] <= lo_r;
      buf_hi[d_r[DIDX_W-1:0]] <= hi_r;
    end
  end

  // ---- result channel ----
  always_comb begin
    out_ch.valid = (state_r == S_EMIT);
    if (empty_r) begin
      out_ch.out_dim      = '0;
      out_ch.result_lower = '0;
      out_ch.result_upper = '0;
      out_ch.result_empty = 1'b1;
      out_ch.last_result  = 1'b1;
    end else begin
      out_ch.out_dim      = qip_pkg::DIM_W'(e_r);
      out_ch.result_lower = buf_lo[e_r[DIDX_W-1:0]];
      out_ch.result_upper = buf_hi[e_r[DIDX_W-1:0]];
      out_ch.result_empty = 1'b0;
      out_ch.last_result  = last_dim_e;
    end
  end
endmodule
`default_nettype wire

### src/qip_cell.sv
// ----------------------------------------------------------------------------
// qip_cell
// One slot of the sorting row: holds one endpoint, insertion and drain.
// ----------------------------------------------------------------------------
`default_nettype none
module qip_cell #(
  parameter int COORD_BITS = qip_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  qip_pkg::ctl_t                ctl,
  input  wire signed [COORD_BITS-1:0]  new_val,
  input  wire                          new_up,
  input  wire signed [COORD_BITS-1:0]  left_val,
  input  wire                          left_up,
  input  wire                          left_vld,
  input  wire                          left_gr,
  input  wire signed [COORD_BITS-1:0]  right_val,
  input  wire                          right_up,
  input  wire                          right_vld,
  output logic signed [COORD_BITS-1:0] val,
  output logic                         up,
  output logic                         vld,
  output logic                         gr
);
  logic signed [COORD_BITS-1:0] val_r, val_nxt;
  logic up_r, up_nxt, vld_r, vld_nxt;

  // new endpoint sorts at or before this slot (empty slot counts as +inf)
  assign gr = !vld_r || (new_val < val_r) || (new_val == val_r && !new_up && up_r);

  always_comb begin
    val_nxt = val_r;
    up_nxt  = up_r;
    vld_nxt = vld_r;
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctl.shift) begin
      val_nxt = right_val;
      up_nxt  = right_up;
      vld_nxt = right_vld;
    end else if (ctl.ins && gr) begin
      if (left_gr) begin
        val_nxt = left_val;
        up_nxt  = left_up;
        vld_nxt = left_vld;
      end else begin
        val_nxt = new_val;
        up_nxt  = new_up;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
    up_r  <= up_nxt;
  end

  assign val = val_r;
  assign up  = up_r;
  assign vld = vld_r;
endmodule
`default_nettype wire

### src/qip_chain.sv
// ----------------------------------------------------------------------------
// qip_chain
// Row of sorting cells; endpoints enter sorted, leave smallest first.
// ----------------------------------------------------------------------------
`default_nettype none
module qip_chain #(
  parameter int NCELL      = 2 * qip_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = qip_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  qip_pkg::ctl_t                ctl,
  input  wire signed [COORD_BITS-1:0]  new_val,
  input  wire                          new_up,
  output logic signed [COORD_BITS-1:0] head_val,
  output logic                         head_up
);
  logic signed [COORD_BITS-1:0] val [NCELL+1];
  logic up [NCELL+1];
  logic vld [NCELL+1];
  logic gr [NCELL];

  // position NCELL is the empty tail beyond the last cell
  assign val[NCELL] = '0;
  assign up[NCELL]  = 1'b0;
  assign vld[NCELL] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < NCELL; i++) begin : g_cell
      if (i == 0) begin : g_head
        qip_cell #(.COORD_BITS(COORD_BITS)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_val(new_val), .new_up(new_up),
          .left_val('0), .left_up(1'b0), .left_vld(1'b0), .left_gr(1'b0),
          .right_val(val[i+1]), .right_up(up[i+1]), .right_vld(vld[i+1]),
          .val(val[i]), .up(up[i]), .vld(vld[i]), .gr(gr[i]));
      end else begin : g_body
        qip_cell #(.COORD_BITS(COORD_BITS)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_val(new_val), .new_up(new_up),
          .left_val(val[i-1]), .left_up(up[i-1]), .left_vld(vld[i-1]),
          .left_gr(gr[i-1]),
          .right_val(val[i+1]), .right_up(up[i+1]), .right_vld(vld[i+1]),
          .val(val[i]), .up(up[i]), .vld(vld[i]), .gr(gr[i]));
      end
    end
  endgenerate

  assign head_val = val[0];
  assign head_up  = up[0];
endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of q_intersection_projection. Loads runs of boxes through the
// input channel, changes threshold and dimension count between runs over the
// cfg_ port, and checks every result interval against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int NBOX = qip_pkg::MAX_BOXES_DEF;
  localparam int NDIM = qip_pkg::MAX_DIMS_DEF;
  localparam int CW = qip_pkg::COORD_BITS_DEF;
  localparam int BW = qip_pkg::BOX_W;
  localparam int DW = qip_pkg::DIM_W;
  localparam int AW = qip_pkg::PADDR_W;
  localparam int PW = qip_pkg::PDATA_W;
  localparam int STALL_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 480;
  localparam logic signed [CW-1:0] NEG_INF = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] POS_INF = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic [BW-1:0] box;
    logic [DW-1:0] dim;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic emp;
    logic last;
  } load_t;

  typedef struct packed {
    logic [DW-1:0] dim;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic emp;
    logic last;
  } span_t;

  typedef struct packed {
    logic is_cfg;
    logic [AW-1:0] addr;
    logic [PW-1:0] data;
    load_t ld;
    logic typed;
    span_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [AW-1:0] cfg_paddr;
  logic [PW-1:0] cfg_pwdata;
  logic [PW-1:0] cfg_prdata;
  logic cfg_pready;

  qip_in_if in_if ();
  qip_out_if out_if ();

  q_intersection_projection dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CW-1:0] lo_mem [NBOX*NDIM];
  logic [CW-1:0] hi_mem [NBOX*NDIM];
  bit written [NBOX*NDIM];
  bit dead_box [NBOX];
  int live_span;
  int q_thr, n_dims;

  span_t span_q[$];
  bit typed_pending;
  span_t typed_want;

  int errors, n_loads, n_spans, n_runs, n_empty, n_cfg;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  function automatic void project_run(input load_t ld, ref span_t res[$]);
    logic signed [CW-1:0] pv [2*NBOX];
    bit pu [2*NBOX];
    logic signed [CW-1:0] tv, lo, hi;
    bit tu, ok, flo, fhi;
    int q, dims, n, c, k;
    span_t s;
    lo_mem[ld.box*NDIM + ld.dim] = ld.lo;
    hi_mem[ld.box*NDIM + ld.dim] = ld.hi;
    if (ld.emp) dead_box[ld.box] = 1'b1;
    if (ld.box + 1 > live_span) live_span = ld.box + 1;
    res = {};
    if (!ld.last) return;
    q = (q_thr == 0) ? 1 : q_thr;
    dims = (n_dims == 0) ? 1 : ((n_dims > NDIM) ? NDIM : n_dims);
    ok = 1'b1;
    for (int d = 0; d < dims && ok; d++) begin
      n = 0;
      for (int b = 0; b < live_span; b++) begin
        if (!dead_box[b]) begin
          pv[n] = lo_mem[b*NDIM + d]; pu[n] = 1'b0; n++;
          pv[n] = hi_mem[b*NDIM + d]; pu[n] = 1'b1; n++;
        end
      end
      if (n == 0) begin
        ok = 1'b0;
      end else begin
        // insertion sort, lower ends ahead of upper ends on a tie
        for (int i = 1; i < n; i++) begin
          tv = pv[i]; tu = pu[i]; k = i;
          while (k > 0 && (tv < pv[k-1] || (tv == pv[k-1] && tu < pu[k-1]))) begin
            pv[k] = pv[k-1]; pu[k] = pu[k-1]; k--;
          end
          pv[k] = tv; pu[k] = tu;
        end
        flo = 1'b0; fhi = 1'b0; lo = '0; hi = '0;
        c = 0;
        for (int i = 0; i < n && !flo; i++) begin
          c += pu[i] ? -1 : 1;
          if (c == q) begin lo = pv[i]; flo = 1'b1; end
        end
        c = 0;
        for (int i = n - 1; i >= 0 && !fhi; i--) begin
          c += pu[i] ? 1 : -1;
          if (c == q) begin hi = pv[i]; fhi = 1'b1; end
        end
        if (!flo || !fhi) begin
          ok = 1'b0;
        end else begin
          s.dim = d[DW-1:0]; s.lo = lo; s.hi = hi; s.emp = 1'b0;
          s.last = (d + 1 == dims);
          res.push_back(s);
        end
      end
    end
    if (!ok) begin
      res = {};
      s = '0; s.emp = 1'b1; s.last = 1'b1;
      res.push_back(s);
    end
    live_span = 0;
    foreach (dead_box[b]) dead_box[b] = 1'b0;
  endfunction

  // input and output requests observed at the same edge, input first
  always @(posedge clk) begin
    span_t got[$];
    span_t e;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        project_run({in_if.box_index, in_if.dim_index, in_if.lower_bound,
                     in_if.upper_bound, in_if.component_empty, in_if.last_item}, got);
        n_loads++;
        if (in_if.last_item) begin
          n_runs++;
          if (typed_pending) begin
            span_q.push_back(typed_want);
            typed_pending = 1'b0;
          end else begin
            foreach (got[i]) span_q.push_back(got[i]);
          end
        end
      end
      if (out_if.valid && out_if.ready) begin
        n_spans++;
        if (out_if.result_empty) n_empty++;
        if (span_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result dim=%0d", out_if.out_dim);
        end else begin
          e = span_q.pop_front();
          if (out_if.out_dim !== e.dim || out_if.result_lower !== e.lo ||
              out_if.result_upper !== e.hi || out_if.result_empty !== e.emp ||
              out_if.last_result !== e.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp dim=%0d lo=%0d hi=%0d emp=%0b last=%0b",
                       e.dim, e.lo, e.hi, e.emp, e.last);
              $display("          got dim=%0d lo=%0d hi=%0d emp=%0b last=%0b",
                       out_if.out_dim, out_if.result_lower, out_if.result_upper,
                       out_if.result_empty, out_if.last_result);
            end
          end
        end
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [AW-1:0] addr, input logic [PW-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr[2] == qip_pkg::REG_THRESHOLD) q_thr = data & 32'h7f;
    else n_dims = data & 32'h1f;
    n_cfg++;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send(input load_t ld);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.box_index <= ld.box; in_if.dim_index <= ld.dim;
    in_if.lower_bound <= ld.lo; in_if.upper_bound <= ld.hi;
    in_if.component_empty <= ld.emp; in_if.last_item <= ld.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    written[ld.box*NDIM + ld.dim] = 1'b1;
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return NEG_INF;
      1: return POS_INF;
      2: return $urandom();
      default: return $signed($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  function automatic load_t make_load(input int b, input int d);
    load_t ld;
    ld.box = b[BW-1:0]; ld.dim = d[DW-1:0];
    ld.lo = pick_coord();
    case ($urandom_range(0, 9))
      0: ld.hi = pick_coord();
      1: ld.hi = POS_INF;
      default: ld.hi = (ld.lo > POS_INF - 300) ? POS_INF
                       : ld.lo + $signed($urandom_range(0, 250));
    endcase
    ld.emp = ($urandom_range(0, 39) == 0);
    ld.last = 1'b0;
    return ld;
  endfunction

  function automatic row_t item_row(input int b, input int d, input int lo, input int hi,
                                    input bit emp, input bit last);
    row_t r = '0;
    r.ld = {b[BW-1:0], d[DW-1:0], lo, hi, emp, last};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [AW-1:0] addr, input int data);
    row_t r = '0;
    r.is_cfg = 1'b1; r.addr = addr; r.data = data;
    return r;
  endfunction

  localparam logic [AW-1:0] A_THR = {qip_pkg::REG_THRESHOLD, 2'b00};
  localparam logic [AW-1:0] A_DIMS = {qip_pkg::REG_DIMS, 2'b00};

  initial begin
    row_t rows[$];
    row_t r;
    load_t run_q[$];
    load_t ld;
    int thr_set[8];
    int dim_set[8];
    int phase, dims, nb, sent, target;
    thr_set = '{1, 2, 64, 127, 0, 3, 1, 2};
    dim_set = '{1, 3, 16, 31, 0, 2, 16, 5};
    in_if.valid = 1'b0; in_if.box_index = '0; in_if.dim_index = '0;
    in_if.lower_bound = '0; in_if.upper_bound = '0;
    in_if.component_empty = 1'b0; in_if.last_item = 1'b0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    live_span = 0; q_thr = 1; n_dims = 1; typed_pending = 1'b0;
    foreach (dead_box[b]) dead_box[b] = 1'b0;
    foreach (written[i]) begin written[i] = 1'b0; lo_mem[i] = '0; hi_mem[i] = '0; end
    send_idle_pct = 34; recv_idle_pct = 59;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, from reset values: threshold 1, one dimension
    r = item_row(0, 0, NEG_INF, POS_INF, 0, 1);
    r.typed = 1'b1; r.want = {4'd0, NEG_INF, POS_INF, 1'b0, 1'b1};
    rows.push_back(r);
    r = item_row(0, 0, 0, 0, 1, 1);
    r.typed = 1'b1; r.want = {4'd0, 32'd0, 32'd0, 1'b1, 1'b1};
    rows.push_back(r);
    rows.push_back(item_row(0, 0, 5, 10, 0, 0));
    rows.push_back(item_row(1, 0, 10, 20, 0, 1));
    rows.push_back(cfg_row(A_THR, 2));
    rows.push_back(item_row(0, 0, 5, 10, 0, 0));
    rows.push_back(item_row(1, 0, 10, 20, 0, 1));
    // threshold above the number of boxes
    r = item_row(0, 0, 0, 1, 0, 1);
    r.typed = 1'b1; r.want = {4'd0, 32'd0, 32'd0, 1'b1, 1'b1};
    rows.push_back(r);
    // inverted interval swept as given
    rows.push_back(item_row(0, 0, 10, 5, 0, 0));
    rows.push_back(item_row(1, 0, 0, 20, 0, 1));
    rows.push_back(item_row(0, 0, -7, 7, 0, 0));
    rows.push_back(item_row(1, 0, -3, 30, 0, 0));
    rows.push_back(item_row(2, 0, 4, 9, 0, 1));
    rows.push_back(cfg_row(A_THR, 0));
    rows.push_back(item_row(0, 0, 1, 2, 0, 1));
    rows.push_back(cfg_row(A_DIMS, 0));
    rows.push_back(item_row(0, 0, 3, 4, 0, 1));
    rows.push_back(cfg_row(A_THR, 1));
    rows.push_back(cfg_row(A_DIMS, 1));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        reg_write(rows[i].addr, rows[i].data);
      end else begin
        if (rows[i].typed) begin
          typed_want = rows[i].want;
          typed_pending = 1'b1;
        end
        send(rows[i].ld);
        if (rows[i].ld.last) begin
          in_if.valid <= 1'b0;
          drain();
        end
      end
    end

    // random part: batches of runs, each with its own settings; the idling
    // mode moves on after each third of the items
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      in_if.valid <= 1'b0;
      drain();
      case ((3 * sent) / RANDOM_ITEMS)
        0: begin send_idle_pct = 34; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      reg_write(A_THR, thr_set[phase % 8]);
      reg_write(A_DIMS, dim_set[phase % 8]);
      dims = (n_dims == 0) ? 1 : ((n_dims > NDIM) ? NDIM : n_dims);
      target = sent + 60;
      while (sent < target) begin
        nb = (dims <= 2 && $urandom_range(0, 11) == 0) ? NBOX : $urandom_range(1, 8);
        run_q = {};
        for (int b = 0; b < nb; b++)
          for (int d = 0; d < dims; d++)
            if (!written[b*NDIM + d] || $urandom_range(0, 5) != 0)
              run_q.push_back(make_load(b, d));
        // sometimes one load to a dimension not in use
        if (dims < NDIM && $urandom_range(0, 2) == 0)
          run_q.push_back(make_load($urandom_range(0, nb - 1),
                                    $urandom_range(dims, NDIM - 1)));
        run_q.shuffle();
        ld = make_load($urandom_range(0, nb - 1), $urandom_range(0, dims - 1));
        ld.last = 1'b1;
        run_q.push_back(ld);
        foreach (run_q[i]) send(run_q[i]);
        sent += run_q.size();
        if ($urandom_range(0, 1) == 0) begin
          in_if.valid <= 1'b0;
          @(posedge clk);
        end
      end
      phase++;
    end
    in_if.valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d loads in %0d runs, %0d result intervals (%0d empty)",
             n_loads, n_runs, n_spans, n_empty);
    $display("%0d register writes over %0d setting phases, %0d errors", n_cfg, phase, errors);
    if (errors == 0 && span_q.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule

### sim.f
src/qip_pkg.sv
src/qip_if.sv
src/qip_cell.sv
src/qip_chain.sv
src/q_intersection_projection.sv
dv/tb_top.sv
